>>> sv/prte_pkg.sv
// Package for the pitchfork ring tether evaluator: data width, register
// indexes, reset values and the payload structs. No dependencies.
package prte_pkg;

  localparam int PRTE_W         = 32;
  localparam int PRTE_FRAC_BITS = 16;
  localparam int PRTE_IDX_W     = 2;

  // Configuration register indexes
  localparam logic [PRTE_IDX_W-1:0] CFG_MU_GAIN      = 2'd0;
  localparam logic [PRTE_IDX_W-1:0] CFG_ALPHA_GAIN   = 2'd1;
  localparam logic [PRTE_IDX_W-1:0] CFG_ORBIT_RADIUS = 2'd2;

  // Reset values (Q16.16)
  localparam logic [PRTE_W-1:0] MU_RESET     = 32'h0001_0000;
  localparam logic [PRTE_W-1:0] ALPHA_RESET  = 32'h0001_0000;
  localparam logic [PRTE_W-1:0] ORBIT_RESET  = 32'h0000_0000;

  typedef struct packed {
    logic signed [PRTE_W-1:0] pos_x;
    logic signed [PRTE_W-1:0] pos_y;
    logic signed [PRTE_W-1:0] pos_z;
  } prte_in_t;

  typedef struct packed {
    logic signed [PRTE_W-1:0] energy_out;
    logic signed [PRTE_W-1:0] force_x;
    logic signed [PRTE_W-1:0] force_y;
    logic signed [PRTE_W-1:0] force_z;
  } prte_out_t;

endpackage

>>> sv/pitchfork_ring_tether_eval_core.sv
// Top level of the pitchfork ring tether evaluator: stage logic, config
// registers and output register. Uses prte_pkg, prte_sqrt_pipe, prte_div_pipe.
//
// Takes one displacement (x, y, z) per transaction and returns the tether
// energy and the three force components, all signed Q16.16 and saturated.
// The pipeline accepts one transaction per cycle and holds as a whole while
// a result at the output is stalled. Its stages at the default width are,
// in order: input, squares, sum, a 32-stage square root, seven stages of
// multiply and saturate, a 64-stage divider for the projected xy forces,
// and the output register. Config registers are written with cfg_we;
// indexes beyond the list are ignored.
module pitchfork_ring_tether_eval_core
  import prte_pkg::*;
#(
  parameter int FRAC_BITS = PRTE_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  prte_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output prte_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [PRTE_IDX_W-1:0] cfg_index,
  input  logic [PRTE_W-1:0]     cfg_wdata
);

  localparam int W  = PRTE_W;
  localparam int W2 = 2 * W;
  localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W2-1:0] LIM_POS = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [W2-1:0] LIM_NEG = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

  // Magnitude of a two's complement word
  function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // Saturate a wide sign-magnitude value to a signed word
  function automatic logic [W-1:0] pack_f(input logic neg, input logic [W2-1:0] m);
    logic [W2-1:0] lim;
    logic [W2-1:0] c;
    lim = neg ? LIM_NEG : LIM_POS;
    c   = (m > lim) ? lim : m;
    return neg ? (~c[W-1:0] + 1'b1) : c[W-1:0];
  endfunction

  // Saturate a sum that has one guard bit
  function automatic logic [W-1:0] sat_f(input logic [W:0] s);
    if (s[W] != s[W-1]) begin
      return s[W] ? MINV : MAXV;
    end
    return s[W-1:0];
  endfunction

  // Scale down by a power of two, rounding the magnitude toward zero
  function automatic logic [W-1:0] sd_f(input logic [W-1:0] v, input int k);
    logic [W-1:0] m;
    m = mag_f(v) >> k;
    return v[W-1] ? (~m + 1'b1) : m;
  endfunction

  logic en;

  // Config registers
  logic [W-1:0] mu_r;
  logic [W-1:0] alpha_r;
  logic [W-1:0] orbit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r    <= MU_RESET;
      alpha_r <= ALPHA_RESET;
      orbit_r <= ORBIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MU_GAIN:      mu_r    <= cfg_wdata;
        CFG_ALPHA_GAIN:   alpha_r <= cfg_wdata;
        CFG_ORBIT_RADIUS: orbit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a finished result is held
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage valids
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r, h_v_r, i_v_r, j_v_r;
  logic s_v;

  // Stage payloads
  prte_in_t      a_pos_r, b_pos_r, c_pos_r, d_pos_r, e_pos_r, f_pos_r;
  prte_in_t      g_pos_r, h_pos_r, i_pos_r;
  prte_in_t      s_pos;
  logic [W2-1:0] b_xx_r, b_yy_r, c_sum_r;
  logic [W-1:0]  s_root;
  logic [W-1:0]  p_sat;
  logic [W-1:0]  d_d_r, d_p_r;
  logic [W2-1:0] e_dd_r, e_az_r;
  logic          e_azn_r;
  logic [W-1:0]  e_d_r, e_p_r;
  logic [W-1:0]  f_d2_r, f_az_r, f_fz_r, f_d_r, f_p_r;
  logic [W2-1:0] g_d4_r, g_mud2_r, g_azz_r;
  logic          g_mun_r, g_azzn_r;
  logic [W-1:0]  g_msd_r, g_d_r, g_p_r, g_fz_r;
  logic [W-1:0]  h_q1_r, h_q2_r, h_q3_r, h_p_r, h_fz_r;
  logic [W-1:0]  h_q1s, h_q2s;
  logic [W2-1:0] h_frp_r;
  logic          h_frn_r;
  logic [W-1:0]  i_ea_r, i_q3s_r, i_fr_r, i_p_r, i_fz_r;
  logic [W-1:0]  j_e_r, j_p_r, j_fz_r;
  logic [W2-1:0] j_nx_r, j_ny_r;
  logic          j_sx_r, j_sy_r, j_pz_r;

  // Valid chain around the two sub-pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0; b_v_r <= 1'b0; c_v_r <= 1'b0; d_v_r <= 1'b0;
      e_v_r <= 1'b0; f_v_r <= 1'b0; g_v_r <= 1'b0; h_v_r <= 1'b0;
      i_v_r <= 1'b0; j_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= s_v;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
      h_v_r <= g_v_r;
      i_v_r <= h_v_r;
      j_v_r <= i_v_r;
    end
  end

  // Input register, squares, sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      a_pos_r <= in_data;
      b_pos_r <= a_pos_r;
      b_xx_r  <= mag_f(a_pos_r.pos_x) * mag_f(a_pos_r.pos_x);
      b_yy_r  <= mag_f(a_pos_r.pos_y) * mag_f(a_pos_r.pos_y);
      c_pos_r <= b_pos_r;
      c_sum_r <= b_xx_r + b_yy_r;
    end
  end

  prte_sqrt_pipe #(
    .RW    (W),
    .TAG_W ($bits(prte_in_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_v_r),
    .in_rad    (c_sum_r),
    .in_tag    (c_pos_r),
    .out_valid (s_v),
    .out_root  (s_root),
    .out_tag   (s_pos)
  );

  // Radius saturates to the positive range
  assign p_sat = s_root[W-1] ? MAXV : s_root;

  // Radial offset, then the squares that feed energy and force
  always_ff @(posedge clk) begin
    if (en) begin
      d_pos_r <= s_pos;
      d_p_r   <= p_sat;
      d_d_r   <= sat_f({1'b0, p_sat} - {orbit_r[W-1], orbit_r});

      e_pos_r <= d_pos_r;
      e_p_r   <= d_p_r;
      e_d_r   <= d_d_r;
      e_dd_r  <= mag_f(d_d_r) * mag_f(d_d_r);
      e_az_r  <= mag_f(alpha_r) * mag_f(d_pos_r.pos_z);
      e_azn_r <= alpha_r[W-1] ^ d_pos_r.pos_z[W-1];

      f_pos_r <= e_pos_r;
      f_p_r   <= e_p_r;
      f_d_r   <= e_d_r;
      f_d2_r  <= pack_f(1'b0, e_dd_r >> FRAC_BITS);
      f_az_r  <= pack_f(e_azn_r, e_az_r >> FRAC_BITS);
      f_fz_r  <= pack_f(!e_azn_r, e_az_r >> FRAC_BITS);
    end
  end

  // Quarter of the fourth power and half of the mu term
  assign h_q1s = sd_f(h_q1_r, 2);
  assign h_q2s = sd_f(h_q2_r, 1);

  // Fourth power, mu terms, axial energy and radial force
  always_ff @(posedge clk) begin
    if (en) begin
      g_pos_r  <= f_pos_r;
      g_p_r    <= f_p_r;
      g_d_r    <= f_d_r;
      g_fz_r   <= f_fz_r;
      g_d4_r   <= f_d2_r * f_d2_r;
      g_mud2_r <= mag_f(mu_r) * f_d2_r;
      g_mun_r  <= mu_r[W-1];
      g_azz_r  <= mag_f(f_az_r) * mag_f(f_pos_r.pos_z);
      g_azzn_r <= f_az_r[W-1] ^ f_pos_r.pos_z[W-1];
      g_msd_r  <= sat_f({mu_r[W-1], mu_r} - {1'b0, f_d2_r});

      h_pos_r <= g_pos_r;
      h_p_r   <= g_p_r;
      h_fz_r  <= g_fz_r;
      h_q1_r  <= pack_f(1'b0, g_d4_r >> FRAC_BITS);
      h_q2_r  <= pack_f(g_mun_r, g_mud2_r >> FRAC_BITS);
      h_q3_r  <= pack_f(g_azzn_r, g_azz_r >> FRAC_BITS);
      h_frp_r <= mag_f(g_msd_r) * mag_f(g_d_r);
      h_frn_r <= g_msd_r[W-1] ^ g_d_r[W-1];

      i_pos_r <= h_pos_r;
      i_p_r   <= h_p_r;
      i_fz_r  <= h_fz_r;
      i_ea_r  <= sat_f({h_q1s[W-1], h_q1s} - {h_q2s[W-1], h_q2s});
      i_q3s_r <= sd_f(h_q3_r, 1);
      i_fr_r  <= pack_f(h_frn_r, h_frp_r >> FRAC_BITS);

      j_e_r  <= sat_f({i_ea_r[W-1], i_ea_r} + {i_q3s_r[W-1], i_q3s_r});
      j_p_r  <= i_p_r;
      j_pz_r <= (i_p_r == '0);
      j_fz_r <= i_fz_r;
      j_nx_r <= mag_f(i_fr_r) * mag_f(i_pos_r.pos_x);
      j_ny_r <= mag_f(i_fr_r) * mag_f(i_pos_r.pos_y);
      j_sx_r <= i_fr_r[W-1] ^ i_pos_r.pos_x[W-1];
      j_sy_r <= i_fr_r[W-1] ^ i_pos_r.pos_y[W-1];
    end
  end

  // Project the radial force onto x and y
  localparam int TAGX_W = 2 * W + 2;

  logic              dx_v, dy_v;
  logic [W2-1:0]     dx_q, dy_q;
  logic [TAGX_W-1:0] dx_tag;
  logic              dy_tag;

  prte_div_pipe #(
    .NW    (W2),
    .DW    (W),
    .TAG_W (TAGX_W)
  ) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (j_v_r),
    .in_num    (j_nx_r),
    .in_den    (j_p_r),
    .in_tag    ({j_e_r, j_fz_r, j_sx_r, j_pz_r}),
    .out_valid (dx_v),
    .out_quo   (dx_q),
    .out_tag   (dx_tag)
  );

  prte_div_pipe #(
    .NW    (W2),
    .DW    (W),
    .TAG_W (1)
  ) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (j_v_r),
    .in_num    (j_ny_r),
    .in_den    (j_p_r),
    .in_tag    (j_sy_r),
    .out_valid (dy_v),
    .out_quo   (dy_q),
    .out_tag   (dy_tag)
  );

  logic          t_pz;
  logic          t_sx;
  logic [W-1:0]  t_e, t_fz;
  assign {t_e, t_fz, t_sx, t_pz} = dx_tag;

  // Output register
  logic      out_valid_r;
  prte_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dx_v && dy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.energy_out <= t_e;
      out_data_r.force_x    <= t_pz ? '0 : pack_f(t_sx, dx_q);
      out_data_r.force_y    <= t_pz ? '0 : pack_f(dy_tag, dy_q);
      out_data_r.force_z    <= t_fz;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Zero radius gives no xy force
  a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (en && dx_v && t_pz) |=> (out_data.force_x == '0 && out_data.force_y == '0))
    else $error("xy force not zero at zero radius");

  // A held pipeline keeps its stage valids
  a_hold_valids: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(a_v_r) && $stable(d_v_r) && $stable(j_v_r) && $stable(dx_v)))
    else $error("stage valid changed while held");

  // Both dividers stay in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dx_v == dy_v)
    else $error("divider valids diverged");

endmodule

>>> sv/prte_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with a side tag.
// Standalone; no package needed.
module prte_sqrt_pipe #(
  parameter int RW    = 32,
  parameter int TAG_W = 96
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [TAG_W-1:0]  out_tag
);

  logic              v_r   [0:RW-1];
  logic [RW+1:0]     rem_r [0:RW-1];
  logic [RW-1:0]     root_r[0:RW-1];
  logic [2*RW-1:0]   rad_r [0:RW-1];
  logic [TAG_W-1:0]  tag_r [0:RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic             v_in;
    logic [RW+1:0]    rem_in;
    logic [RW-1:0]    root_in;
    logic [2*RW-1:0]  rad_in;
    logic [TAG_W-1:0] tag_in;
    logic [RW+1:0]    cur;
    logic [RW+1:0]    trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign tag_in  = tag_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign cur   = {rem_in[RW-1:0], rad_in[2*RW-1:2*RW-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (cur - trial) : cur;
        root_r[k] <= {root_in[RW-2:0], ge};
        rad_r[k]  <= {rad_in[2*RW-3:0], 2'b00};
        tag_r[k]  <= tag_in;
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_tag   = tag_r[RW-1];

endmodule

>>> sv/prte_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Standalone; no package needed.
module prte_div_pipe #(
  parameter int NW    = 64,
  parameter int DW    = 32,
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     in_num,
  input  logic [DW-1:0]     in_den,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [NW-1:0]     out_quo,
  output logic [TAG_W-1:0]  out_tag
);

  logic              v_r  [0:NW-1];
  logic [DW-1:0]     rem_r[0:NW-1];
  logic [NW-1:0]     sh_r [0:NW-1];
  logic [DW-1:0]     den_r[0:NW-1];
  logic [TAG_W-1:0]  tag_r[0:NW-1];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic             v_in;
    logic [DW-1:0]    rem_in;
    logic [NW-1:0]    sh_in;
    logic [DW-1:0]    den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DW:0]      cur;
    logic [DW:0]      diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign sh_in  = in_num;
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign rem_in = rem_r[k-1];
      assign sh_in  = sh_r[k-1];
      assign den_in = den_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    // Shift in one dividend bit, subtract the divisor when it fits
    assign cur  = {rem_in, sh_in[NW-1]};
    assign ge   = (cur >= {1'b0, den_in});
    assign diff = cur - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : cur[DW-1:0];
        sh_r[k]  <= {sh_in[NW-2:0], ge};
        den_r[k] <= den_in;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quo   = sh_r[NW-1];
  assign out_tag   = tag_r[NW-1];

endmodule
